// ===== sv/wsil_pkg.sv =====
package wsil_pkg;

  // input functions
  localparam logic [1:0] FN_LOAD_PT = 2'd0;
  localparam logic [1:0] FN_DIST    = 2'd1;
  localparam logic [1:0] FN_RUN     = 2'd2;

  // register indexes (byte address bit 2)
  localparam logic REG_NUM_POINTS   = 1'b0;
  localparam logic REG_NUM_CLUSTERS = 1'b1;

  // register reset values
  localparam logic [6:0] NUM_POINTS_RST   = 7'd64;
  localparam logic [4:0] NUM_CLUSTERS_RST = 5'd16;

  // fixed field widths
  localparam int LAB_W    = 8;
  localparam int WT_W     = 16;
  localparam int DIST_W   = 24;
  localparam int SCORE_W  = 16;
  localparam int SCORE_FB = 15;
  localparam int ONE_Q8   = 256;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 16'h7fff;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIZE_INIT,
    ST_SIZE_RD,
    ST_SIZE_ACC,
    ST_PT_INIT,
    ST_PT_LAB,
    ST_ACC_RD,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_B_CHK,
    ST_B_WAIT,
    ST_B_NEXT,
    ST_AU_START,
    ST_AU_WAIT,
    ST_AW_START,
    ST_AW_WAIT,
    ST_SU_START,
    ST_SU_WAIT,
    ST_SW_START,
    ST_SW_WAIT,
    ST_EMIT
  } wsil_state_t;

  // what the shared divider is working on
  typedef enum logic [2:0] {
    DS_B,
    DS_AU,
    DS_AW,
    DS_SU,
    DS_SW
  } div_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     size_clr;
    logic     size_acc;
    logic     i_clr;
    logic     i_inc;
    logic     j_clr;
    logic     j_inc;
    logic     c_clr;
    logic     c_inc;
    logic     rd_i;
    logic     pt_clr;
    logic     own_latch;
    logic     mul_en;
    logic     sum_acc;
    logic     div_start;
    logic     res_ld;
    div_sel_t div_sel;
    logic     emit;
  } wsil_cmd_t;

  typedef struct packed {
    logic run_go;
    logic run_empty;
    logic j_last;
    logic i_last;
    logic c_last;
    logic own_ok;
    logic b_cand;
    logic have_b;
    logic div_busy;
    logic div_done;
    logic den_u_zero;
    logic den_w_zero;
    logic out_free;
  } wsil_stat_t;

endpackage

// ===== sv/wsil_div.sv =====
module wsil_div #(
  parameter int DVD_W = 70,
  parameter int DVS_W = 54
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_r, quo_r[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
    diff   = rem_sh - {1'b0, dvs_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/wsil_dp.sv =====
module wsil_dp #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsil_pkg::wsil_cmd_t  cmd,
  output wsil_pkg::wsil_stat_t stat,
  input  logic [6:0]           num_points,
  input  logic [4:0]           num_clusters,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  input  logic [5:0]           in_row_index,
  input  logic [5:0]           in_col_index,
  input  logic [23:0]          in_distance,
  input  logic [7:0]           in_label,
  input  logic [15:0]          in_weight,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           out_point_index,
  output logic signed [15:0]   out_score_unweighted,
  output logic                 out_valid_unweighted,
  output logic signed [15:0]   out_score_weighted,
  output logic                 out_valid_weighted,
  output logic                 out_last
);

  import wsil_pkg::*;

  localparam int PW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int CW   = $clog2(MAX_CLUSTERS);
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int DAW  = $clog2(MAX_POINTS * MAX_POINTS);
  localparam int ZW   = WT_W + PW;
  localparam int PRW  = WT_W + DIST_W;
  localparam int SUMW = PRW + PW;
  localparam int AVW  = SUMW + 8;
  localparam int DVW  = AVW + SCORE_FB;

  // clamped configuration
  logic [NW-1:0] n_eff;
  logic [KW-1:0] kc_eff;

  always_comb begin
    n_eff  = (32'(num_points) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points);
    kc_eff = (32'(num_clusters) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) : KW'(num_clusters);
  end

  // input writes
  logic           accept;
  logic           pt_we;
  logic           dist_we;
  logic [DAW-1:0] dist_waddr;

  assign accept     = in_valid && cmd.in_ready;
  assign pt_we      = accept && (in_func == FN_LOAD_PT) && (32'(in_row_index) < MAX_POINTS);
  assign dist_we    = accept && (in_func == FN_DIST) && (32'(in_row_index) < MAX_POINTS)
                      && (32'(in_col_index) < MAX_POINTS);
  assign dist_waddr = DAW'(32'(in_row_index) * MAX_POINTS + 32'(in_col_index));

  // counters
  logic [PW-1:0] i_r;
  logic [PW-1:0] j_r;
  logic [CW-1:0] c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      c_r <= '0;
    end else begin
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + PW'(1);
      end
      if (cmd.j_clr) begin
        j_r <= '0;
      end else if (cmd.j_inc) begin
        j_r <= j_r + PW'(1);
      end
      if (cmd.c_clr) begin
        c_r <= '0;
      end else if (cmd.c_inc) begin
        c_r <= c_r + CW'(1);
      end
    end
  end

  // label and weight memory
  logic [LAB_W+WT_W-1:0] pt_mem [MAX_POINTS];
  logic [LAB_W+WT_W-1:0] pt_rdata_r;
  logic [PW-1:0]         pt_raddr;

  assign pt_raddr = cmd.rd_i ? i_r : j_r;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[PW'(in_row_index)] <= {in_label, in_weight};
    end
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  // distance memory
  logic [DIST_W-1:0] dist_mem [MAX_POINTS*MAX_POINTS];
  logic [DIST_W-1:0] dist_rdata_r;
  logic [DAW-1:0]    dist_raddr;

  assign dist_raddr = DAW'(32'(i_r) * MAX_POINTS + 32'(j_r));

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= in_distance;
    end
    dist_rdata_r <= dist_mem[dist_raddr];
  end

  // decode of the point read from memory
  logic [LAB_W-1:0] mem_lab;
  logic [WT_W-1:0]  mem_wt;
  logic             mem_lab_ok;
  logic [CW-1:0]    mem_lab_idx;

  always_comb begin
    mem_lab     = pt_rdata_r[LAB_W+WT_W-1:WT_W];
    mem_wt      = pt_rdata_r[WT_W-1:0];
    mem_lab_ok  = (mem_lab != '0) && (32'(mem_lab) <= 32'(kc_eff));
    mem_lab_idx = CW'(mem_lab - LAB_W'(1));
  end

  // cluster sizes, one read port
  logic [ZW-1:0] size_r [MAX_CLUSTERS];
  logic [CW-1:0] size_addr;
  logic [ZW-1:0] size_rd;

  assign size_addr = (cmd.size_acc || cmd.own_latch) ? mem_lab_idx : c_r;
  assign size_rd   = size_r[size_addr];

  always_ff @(posedge clk) begin
    if (cmd.size_clr) begin
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
        size_r[k] <= '0;
      end
    end else if (cmd.size_acc && mem_lab_ok) begin
      size_r[size_addr] <= size_rd + ZW'(mem_wt);
    end
  end

  // own cluster of the current point
  logic [CW-1:0] ci_idx_r;
  logic [ZW-1:0] own_size_r;

  always_ff @(posedge clk) begin
    if (cmd.own_latch) begin
      ci_idx_r   <= mem_lab_idx;
      own_size_r <= size_rd;
    end
  end

  // weight times distance, registered
  logic [PRW-1:0] prod_r;
  logic           skip_r;
  logic           own_hit_r;
  logic [CW-1:0]  lab_j_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r      <= PRW'(mem_wt) * PRW'(dist_rdata_r);
      skip_r      <= (j_r == i_r) || !mem_lab_ok;
      own_hit_r   <= mem_lab_idx == ci_idx_r;
      lab_j_idx_r <= mem_lab_idx;
    end
  end

  // per-cluster distance sums, one read port
  logic [SUMW-1:0] dsum_r [MAX_CLUSTERS];
  logic [SUMW-1:0] own_sum_r;
  logic [CW-1:0]   dsum_addr;
  logic [SUMW-1:0] dsum_rd;

  assign dsum_addr = cmd.sum_acc ? lab_j_idx_r : c_r;
  assign dsum_rd   = dsum_r[dsum_addr];

  always_ff @(posedge clk) begin
    if (cmd.pt_clr) begin
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
        dsum_r[k] <= '0;
      end
      own_sum_r <= '0;
    end else if (cmd.sum_acc && !skip_r) begin
      if (own_hit_r) begin
        own_sum_r <= own_sum_r + SUMW'(prod_r);
      end else begin
        dsum_r[dsum_addr] <= dsum_rd + SUMW'(prod_r);
      end
    end
  end

  // averages and scores
  logic [AVW-1:0]     b_r;
  logic               have_b_r;
  logic [AVW-1:0]     au_r;
  logic [AVW-1:0]     aw_r;
  logic [SCORE_W-1:0] su_r;
  logic [SCORE_W-1:0] sw_r;
  logic               vu_r;
  logic               vw_r;
  logic [AVW-1:0]     den_u;
  logic [AVW-1:0]     den_w;
  logic [AVW-1:0]     dif_u;
  logic [AVW-1:0]     dif_w;

  always_comb begin
    den_u = (au_r > b_r) ? au_r : b_r;
    den_w = (aw_r > b_r) ? aw_r : b_r;
    dif_u = (b_r < au_r) ? (au_r - b_r) : (b_r - au_r);
    dif_w = (b_r < aw_r) ? (aw_r - b_r) : (b_r - aw_r);
  end

  // shared divider
  logic [DVW-1:0] div_dvd;
  logic [AVW-1:0] div_dvs;
  logic           div_busy;
  logic           div_done;
  logic [DVW-1:0] div_quo;
  logic [AVW-1:0] avg;

  always_comb begin
    unique case (cmd.div_sel)
      DS_B: begin
        div_dvd = DVW'({dsum_rd, 8'b0});
        div_dvs = AVW'(size_rd);
      end
      DS_AU: begin
        div_dvd = DVW'({own_sum_r, 8'b0});
        div_dvs = AVW'(own_size_r - ZW'(ONE_Q8));
      end
      DS_AW: begin
        div_dvd = DVW'({own_sum_r, 8'b0});
        div_dvs = AVW'(own_size_r);
      end
      DS_SU: begin
        div_dvd = {dif_u, SCORE_FB'(0)};
        div_dvs = den_u;
      end
      DS_SW: begin
        div_dvd = {dif_w, SCORE_FB'(0)};
        div_dvs = den_w;
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  wsil_div #(
    .DVD_W(DVW),
    .DVS_W(AVW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quo)
  );

  assign avg = div_quo[AVW-1:0];

  // sign and saturation of a score
  function automatic logic [SCORE_W-1:0] fix_score(input logic neg, input logic [SCORE_W-1:0] q);
    logic [SCORE_W-1:0] r;
    begin
      if (neg) begin
        r = SCORE_W'(0) - q;
      end else if (q > SCORE_MAX) begin
        r = SCORE_MAX;
      end else begin
        r = q;
      end
      return r;
    end
  endfunction

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.pt_clr) begin
      have_b_r <= 1'b0;
      vu_r     <= 1'b0;
      vw_r     <= 1'b0;
      su_r     <= '0;
      sw_r     <= '0;
    end else if (cmd.res_ld) begin
      unique case (cmd.div_sel)
        DS_B: begin
          if (!have_b_r || avg <= b_r) begin
            b_r      <= avg;
            have_b_r <= 1'b1;
          end
        end
        DS_AU: begin
          au_r <= avg;
        end
        DS_AW: begin
          aw_r <= avg;
        end
        DS_SU: begin
          su_r <= fix_score(b_r < au_r, div_quo[SCORE_W-1:0]);
          vu_r <= 1'b1;
        end
        DS_SW: begin
          sw_r <= fix_score(b_r < aw_r, div_quo[SCORE_W-1:0]);
          vw_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  logic               out_valid_r;
  logic [5:0]         out_idx_r;
  logic [SCORE_W-1:0] out_su_r;
  logic [SCORE_W-1:0] out_sw_r;
  logic               out_vu_r;
  logic               out_vw_r;
  logic               out_last_r;
  logic               i_last;

  assign i_last = (NW'(i_r) + NW'(1)) == n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= 6'(i_r);
      out_su_r   <= su_r;
      out_sw_r   <= sw_r;
      out_vu_r   <= vu_r;
      out_vw_r   <= vw_r;
      out_last_r <= i_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_point_index      = out_idx_r;
  assign out_score_unweighted = out_su_r;
  assign out_valid_unweighted = out_vu_r;
  assign out_score_weighted   = out_sw_r;
  assign out_valid_weighted   = out_vw_r;
  assign out_last             = out_last_r;

  // status to the controller
  always_comb begin
    stat.run_go     = accept && (in_func == FN_RUN);
    stat.run_empty  = n_eff == '0;
    stat.j_last     = (NW'(j_r) + NW'(1)) == n_eff;
    stat.i_last     = i_last;
    stat.c_last     = (KW'(c_r) + KW'(1)) == kc_eff;
    stat.own_ok     = mem_lab_ok && (size_rd > ZW'(ONE_Q8));
    stat.b_cand     = (c_r != ci_idx_r) && (size_rd != '0);
    stat.have_b     = have_b_r;
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.den_u_zero = den_u == '0;
    stat.den_w_zero = den_w == '0;
    stat.out_free   = !out_valid_r || out_ready;
  end

endmodule

// ===== sv/wsil_ctrl.sv =====
module wsil_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsil_pkg::wsil_stat_t stat,
  output wsil_pkg::wsil_cmd_t  cmd
);

  import wsil_pkg::*;

  wsil_state_t state_r;
  wsil_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (stat.run_go && !stat.run_empty) state_nxt = ST_SIZE_INIT;
      end
      ST_SIZE_INIT: state_nxt = ST_SIZE_RD;
      ST_SIZE_RD:   state_nxt = ST_SIZE_ACC;
      ST_SIZE_ACC:  state_nxt = stat.j_last ? ST_PT_INIT : ST_SIZE_RD;
      ST_PT_INIT:   state_nxt = ST_PT_LAB;
      ST_PT_LAB:    state_nxt = stat.own_ok ? ST_ACC_RD : ST_EMIT;
      ST_ACC_RD:    state_nxt = ST_ACC_MUL;
      ST_ACC_MUL:   state_nxt = ST_ACC_ADD;
      ST_ACC_ADD:   state_nxt = stat.j_last ? ST_B_CHK : ST_ACC_RD;
      ST_B_CHK:     state_nxt = stat.b_cand ? ST_B_WAIT : ST_B_NEXT;
      ST_B_WAIT: begin
        if (stat.div_done) state_nxt = ST_B_NEXT;
      end
      ST_B_NEXT:    state_nxt = stat.c_last ? ST_AU_START : ST_B_CHK;
      ST_AU_START:  state_nxt = stat.have_b ? ST_AU_WAIT : ST_EMIT;
      ST_AU_WAIT: begin
        if (stat.div_done) state_nxt = ST_AW_START;
      end
      ST_AW_START:  state_nxt = ST_AW_WAIT;
      ST_AW_WAIT: begin
        if (stat.div_done) state_nxt = ST_SU_START;
      end
      ST_SU_START:  state_nxt = stat.den_u_zero ? ST_SW_START : ST_SU_WAIT;
      ST_SU_WAIT: begin
        if (stat.div_done) state_nxt = ST_SW_START;
      end
      ST_SW_START:  state_nxt = stat.den_w_zero ? ST_EMIT : ST_SW_WAIT;
      ST_SW_WAIT: begin
        if (stat.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = stat.i_last ? ST_IDLE : ST_PT_INIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.div_sel = DS_B;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      ST_SIZE_INIT: begin
        cmd.size_clr = 1'b1;
        cmd.i_clr    = 1'b1;
        cmd.j_clr    = 1'b1;
      end
      ST_SIZE_RD: begin
      end
      ST_SIZE_ACC: begin
        cmd.size_acc = 1'b1;
        cmd.j_inc    = !stat.j_last;
      end
      ST_PT_INIT: begin
        cmd.pt_clr = 1'b1;
        cmd.rd_i   = 1'b1;
      end
      ST_PT_LAB: begin
        cmd.own_latch = 1'b1;
        cmd.j_clr     = 1'b1;
        cmd.c_clr     = 1'b1;
      end
      ST_ACC_RD: begin
      end
      ST_ACC_MUL: begin
        cmd.mul_en = 1'b1;
      end
      ST_ACC_ADD: begin
        cmd.sum_acc = 1'b1;
        cmd.j_inc   = !stat.j_last;
      end
      ST_B_CHK: begin
        cmd.div_start = stat.b_cand;
      end
      ST_B_WAIT: begin
        cmd.res_ld = stat.div_done;
      end
      ST_B_NEXT: begin
        cmd.c_inc = !stat.c_last;
      end
      ST_AU_START: begin
        cmd.div_sel   = DS_AU;
        cmd.div_start = stat.have_b;
      end
      ST_AU_WAIT: begin
        cmd.div_sel = DS_AU;
        cmd.res_ld  = stat.div_done;
      end
      ST_AW_START: begin
        cmd.div_sel   = DS_AW;
        cmd.div_start = 1'b1;
      end
      ST_AW_WAIT: begin
        cmd.div_sel = DS_AW;
        cmd.res_ld  = stat.div_done;
      end
      ST_SU_START: begin
        cmd.div_sel   = DS_SU;
        cmd.div_start = !stat.den_u_zero;
      end
      ST_SU_WAIT: begin
        cmd.div_sel = DS_SU;
        cmd.res_ld  = stat.div_done;
      end
      ST_SW_START: begin
        cmd.div_sel   = DS_SW;
        cmd.div_start = !stat.den_w_zero;
      end
      ST_SW_WAIT: begin
        cmd.div_sel = DS_SW;
        cmd.res_ld  = stat.div_done;
      end
      ST_EMIT: begin
        cmd.emit  = stat.out_free;
        cmd.i_inc = stat.out_free && !stat.i_last;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/weighted_silhouette_scores.sv =====
// Weighted silhouette scores over a loaded dissimilarity matrix.
// Input channel (in_valid/in_ready): in_func selects a request. A label and
// weight load or a distance load is taken while idle and writes the
// point memory or the distance memory; such requests give no result.
// A run request computes one result per point in use, in point order,
// with out_last on the final one; nothing else is taken until the run ends.
// Run steps: the cluster sizes are summed over all points (read, add), then
// per point the distances are accumulated (memory read, multiply, add) and
// up to num_clusters + 3 divisions run on the one shared restoring divider.
// A point with an invalid label or a small own cluster skips the divisions.
// Result channel (out_valid/out_ready): a single output register; the next
// point is worked on while a result waits, and the run pauses only when a
// new result is ready and the previous one has not been taken.
// Configuration (APB, pready always high): num_points at 0x0, num_clusters
// at 0x4; write only while the block is idle.
// Reset (synchronous, rst_n low) returns to idle and restores the registers;
// the memories keep no reset value and must be loaded before a run.
module weighted_silhouette_scores #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic [23:0]        in_distance,
  input  logic [7:0]         in_label,
  input  logic [15:0]        in_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_point_index,
  output logic signed [15:0] out_score_unweighted,
  output logic               out_valid_unweighted,
  output logic signed [15:0] out_score_weighted,
  output logic               out_valid_weighted,
  output logic               out_last
);

  import wsil_pkg::*;

  logic [6:0] num_points_r;
  logic [4:0] num_clusters_r;
  logic       cfg_wr;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r   <= NUM_POINTS_RST;
      num_clusters_r <= NUM_CLUSTERS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_NUM_POINTS:   num_points_r   <= pwdata[6:0];
        REG_NUM_CLUSTERS: num_clusters_r <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_POINTS:   prdata = {25'b0, num_points_r};
      REG_NUM_CLUSTERS: prdata = {27'b0, num_clusters_r};
      default:          prdata = '0;
    endcase
  end

  wsil_cmd_t  cmd;
  wsil_stat_t stat;

  wsil_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  wsil_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .num_points          (num_points_r),
    .num_clusters        (num_clusters_r),
    .in_valid            (in_valid),
    .in_func             (in_func),
    .in_row_index        (in_row_index),
    .in_col_index        (in_col_index),
    .in_distance         (in_distance),
    .in_label            (in_label),
    .in_weight           (in_weight),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_point_index     (out_point_index),
    .out_score_unweighted(out_score_unweighted),
    .out_valid_unweighted(out_valid_unweighted),
    .out_score_weighted  (out_score_weighted),
    .out_valid_weighted  (out_valid_weighted),
    .out_last            (out_last)
  );

  assign in_ready = cmd.in_ready;

  // a run with points in use makes the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.run_go && !stat.run_empty |=> !in_ready)
    else $error("input still taken after a run request");

  // the divider is never restarted mid-division
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // a result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result overwrote a pending one");

endmodule
